// ----- rtl/core/mstk_pkg.sv -----
// mstk_pkg: shared constants for the kruskal spanning tree core
// no dependencies
`timescale 1ns / 1ps
package mstk_pkg;
  localparam int unsigned MaxVertices = 16;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned VcountBits  = 5;
  localparam int unsigned ResetVcount = 16;
  localparam int unsigned RegVcount   = 0;
  localparam logic [VcountBits-1:0] ResetVcountVal = VcountBits'(ResetVcount);
endpackage

// ----- rtl/core/mstk_uf.sv -----
// mstk_uf: union-find parent forest, read combinationally and written one entry at a time
// depends on mstk_pkg
`timescale 1ns / 1ps
module mstk_uf #(
  parameter int unsigned VertBits = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic [VertBits-1:0] rd_idx_i,
  output logic [VertBits-1:0] rd_par_o,
  input  logic                wr_en_i,
  input  logic [VertBits-1:0] wr_idx_i,
  input  logic [VertBits-1:0] wr_par_i
);
  import mstk_pkg::*;
  localparam int unsigned NV = 1 << VertBits;
  logic [VertBits-1:0] par_q [NV];

  assign rd_par_o = par_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NV; v++) par_q[v] <= VertBits'(v);
    end else if (clear_i) begin
      for (int v = 0; v < NV; v++) par_q[v] <= VertBits'(v);
    end else if (wr_en_i) begin
      par_q[wr_idx_i] <= wr_par_i;
    end
  end
endmodule

// ----- rtl/core/minimum_spanning_tree_kruskal_core.sv -----
// minimum_spanning_tree_kruskal_core: kruskal minimum spanning forest over a streamed matrix
// depends on mstk_pkg and mstk_uf
//
// channel  dir  payload
// s_axis   in   tdata weight
// m_axis   out  tdata from,to,weight,has_edge; tlast last
// apb      cfg  vertex_count at 0x0
//
// loading accepts an entry whenever s_axis_tvalid is high; after the last entry the core
// scans the edge memory twice per distinct weight (minimum search, then matching scan),
// and walks to the roots of both endpoints of each matching edge to keep or drop it.
// reset is asynchronous and puts the block ready with empty state; no clearing pass
// the block takes no item while finishing and stalls while a result waits
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal_core #(
  parameter int unsigned MAX_VERTICES = mstk_pkg::MaxVertices,
  parameter int unsigned WEIGHT_BITS  = mstk_pkg::WeightBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // weight[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // from[3:0] to[7:4] edge_weight[23:8] has_edge[24]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mstk_pkg::*;
  localparam int unsigned VB  = $clog2(MAX_VERTICES);
  localparam int unsigned SD  = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AB  = $clog2(SD);
  localparam int unsigned CB  = AB + 1;
  localparam int unsigned EW  = 2 * VB + WEIGHT_BITS;

  typedef enum logic [3:0] {
    S_LOAD, S_MIN_RD, S_MIN_CHK, S_SCAN_RD, S_SCAN_CHK,
    S_FIND_A, S_FIND_B, S_OUT, S_DONE
  } state_e;

  state_e state_q;
  logic [VcountBits-1:0] vcnt_q;
  logic [CB-1:0] total_q, ent_q;
  logic [VB-1:0] row_q, col_q;
  logic [EW-1:0] mem [SD];
  logic [EW-1:0] rd_q;
  logic [CB-1:0] idx_q;
  logic [WEIGHT_BITS-1:0] cur_w_q, min_w_q;
  logic first_q, min_found_q, kept_q;
  logic [VB-1:0] ra_q, rb_q, walk_q;
  logic [VB-1:0] o_from_q, o_to_q;
  logic [WEIGHT_BITS-1:0] o_w_q;
  logic o_has_q, o_last_q, pend_q;
  logic [VB-1:0] p_from_q, p_to_q;
  logic [WEIGHT_BITS-1:0] p_w_q;
  logic uf_clear, uf_wr;
  logic [VB-1:0] uf_par;
  logic [VB:0] side;
  logic [CB-1:0] side_sq;
  logic [WEIGHT_BITS-1:0] w_in, rd_w;
  logic [VB-1:0] rd_src, rd_dst;
  logic cfg_wr, acc_in, out_fire;

  always_comb begin
    if (vcnt_q < 5'd2) side = (VB+1)'(2);
    else if (32'(vcnt_q) > MAX_VERTICES) side = (VB+1)'(MAX_VERTICES);
    else side = (VB+1)'(vcnt_q);
  end
  assign side_sq = CB'(side) * CB'(side);
  assign w_in    = WEIGHT_BITS'(s_axis_tdata);
  assign rd_w    = rd_q[WEIGHT_BITS-1:0];
  assign rd_src  = rd_q[EW-1 -: VB];
  assign rd_dst  = rd_q[WEIGHT_BITS +: VB];
  assign cfg_wr  = psel && penable && pwrite && (paddr == 2'(RegVcount * 4));
  assign pready  = 1'b1;
  assign prdata  = 32'(vcnt_q);
  assign s_axis_tready = (state_q == S_LOAD);
  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign uf_clear = cfg_wr || (state_q == S_DONE);
  assign uf_wr   = (state_q == S_FIND_B) && (uf_par == walk_q) && (ra_q != walk_q);
  assign out_fire = (!m_axis_tvalid || m_axis_tready) &&
                    ((state_q == S_OUT) || (uf_wr && pend_q));

  mstk_uf #(.VertBits(VB)) u_uf (
    .clk_i, .rst_ni, .clear_i(uf_clear), .rd_idx_i(walk_q), .rd_par_o(uf_par),
    .wr_en_i(uf_wr), .wr_idx_i(ra_q), .wr_par_i(walk_q)
  );

  always_ff @(posedge clk_i) begin
    if (acc_in && (w_in != '0) && (total_q < CB'(SD)))
      mem[total_q[AB-1:0]] <= {row_q, col_q, w_in};
    rd_q <= mem[idx_q[AB-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; vcnt_q <= ResetVcountVal;
      total_q <= '0; ent_q <= '0; row_q <= '0; col_q <= '0;
      idx_q <= '0; cur_w_q <= '0; min_w_q <= '0; first_q <= 1'b1;
      min_found_q <= 1'b0; kept_q <= 1'b0; ra_q <= '0; rb_q <= '0; walk_q <= '0;
      o_from_q <= '0; o_to_q <= '0; o_w_q <= '0; o_has_q <= 1'b0; o_last_q <= 1'b0;
      m_axis_tvalid <= 1'b0; pend_q <= 1'b0;
      p_from_q <= '0; p_to_q <= '0; p_w_q <= '0;
    end else begin
      if (out_fire) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_wr) begin
        vcnt_q <= pwdata[VcountBits-1:0];
        total_q <= '0; ent_q <= '0; row_q <= '0; col_q <= '0;
      end else unique case (state_q)
        S_LOAD: if (acc_in) begin
          if ((w_in != '0) && (total_q < CB'(SD))) total_q <= total_q + 1'b1;
          ent_q <= ent_q + 1'b1;
          if (32'(col_q) + 1 == 32'(side)) begin
            col_q <= '0; row_q <= row_q + 1'b1;
          end else col_q <= col_q + 1'b1;
          if (ent_q + 1'b1 == side_sq) begin
            state_q <= S_MIN_RD; idx_q <= '0; first_q <= 1'b1;
            min_found_q <= 1'b0; kept_q <= 1'b0; pend_q <= 1'b0;
          end
        end
        // find the smallest stored weight, after the first pass strictly above the previous one
        S_MIN_RD: begin
          if (idx_q >= total_q) begin
            if (min_found_q) begin
              cur_w_q <= min_w_q; first_q <= 1'b0; idx_q <= '0;
              min_found_q <= 1'b0; state_q <= S_SCAN_RD;
            end else state_q <= S_OUT;
          end else state_q <= S_MIN_CHK;
        end
        S_MIN_CHK: begin
          if ((first_q || rd_w > cur_w_q) && (!min_found_q || rd_w < min_w_q)) begin
            min_w_q <= rd_w; min_found_q <= 1'b1;
          end
          idx_q <= idx_q + 1'b1; state_q <= S_MIN_RD;
        end
        S_SCAN_RD: begin
          if (idx_q >= total_q) begin
            idx_q <= '0; state_q <= S_MIN_RD;
          end else state_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rd_w == cur_w_q) begin
            walk_q <= rd_src; state_q <= S_FIND_A;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
          end
        end
        S_FIND_A: begin
          if (uf_par == walk_q) begin
            ra_q <= walk_q; walk_q <= rd_dst; state_q <= S_FIND_B;
          end else walk_q <= uf_par;
        end
        S_FIND_B: begin
          if (uf_par == walk_q) begin
            rb_q <= walk_q;
            if (ra_q != walk_q) begin
              if (pend_q) begin
                if (!m_axis_tvalid || m_axis_tready) begin
                  o_from_q <= p_from_q; o_to_q <= p_to_q; o_w_q <= p_w_q;
                  o_has_q <= 1'b1; o_last_q <= 1'b0;
                  p_from_q <= rd_src; p_to_q <= rd_dst; p_w_q <= rd_w;
                  idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
                end
              end else begin
                pend_q <= 1'b1; kept_q <= 1'b1;
                p_from_q <= rd_src; p_to_q <= rd_dst; p_w_q <= rd_w;
                idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
              end
            end else begin
              idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
            end
          end else walk_q <= uf_par;
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          o_from_q <= pend_q ? p_from_q : '0;
          o_to_q   <= pend_q ? p_to_q : '0;
          o_w_q    <= pend_q ? p_w_q : '0;
          o_has_q  <= pend_q; o_last_q <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          total_q <= '0; ent_q <= '0; row_q <= '0; col_q <= '0;
          pend_q <= 1'b0; state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, o_has_q, 16'(o_w_q), 4'(o_to_q), 4'(o_from_q)};
  assign m_axis_tlast = o_last_q;

  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_LOAD) else $error("ready outside load");
  a_last_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !o_has_q) |-> o_last_q) else $error("marker without last");
  a_kept_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD && pend_q) |-> kept_q) else $error("pending without kept");
endmodule

// ----- dv/mstk_scoreboard.sv -----
// mstk_scoreboard: watches the weight, tree edge and apb channels of the kruskal core,
// predicts each spanning forest and compares it field by field; depends on mstk_pkg
`timescale 1ns / 1ps
module mstk_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic        m_last_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          errors_o,
  output int          pending_o
);
  localparam int Depth = mstk_pkg::MaxVertices * mstk_pkg::MaxVertices;

  typedef struct packed {
    logic [3:0]  from_v;
    logic [3:0]  to_v;
    logic [15:0] wt;
    logic        has_edge;
    logic        last;
  } tree_edge_t;

  tree_edge_t tree_q[$];
  logic [4:0]  side_reg;
  logic [3:0]  edge_src[Depth];
  logic [3:0]  edge_dst[Depth];
  logic [15:0] edge_wt[Depth];
  int          edge_cnt;
  int          entry_cnt;
  int          parent[mstk_pkg::MaxVertices];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = tree_q.size();

  function automatic int side();
    if (side_reg < 2) return 2;
    if (side_reg > mstk_pkg::MaxVertices) return mstk_pkg::MaxVertices;
    return int'(side_reg);
  endfunction

  function automatic void clear_load();
    edge_cnt  = 0;
    entry_cnt = 0;
    for (int v = 0; v < mstk_pkg::MaxVertices; v++) parent[v] = v;
  endfunction

  function automatic int root_of(int v);
    int p;
    for (int g = 0; g < mstk_pkg::MaxVertices; g++) begin
      p = parent[v];
      if (p == v) break;
      v = p;
    end
    return v;
  endfunction

  function automatic void build_forest();
    int order[Depth];
    int key, j, ra, rb, kept;
    tree_edge_t e;
    kept = 0;
    for (int i = 0; i < edge_cnt; i++) order[i] = i;
    for (int i = 1; i < edge_cnt; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && edge_wt[order[j-1]] > edge_wt[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (int i = 0; i < edge_cnt; i++) begin
      ra = root_of(edge_src[order[i]]);
      rb = root_of(edge_dst[order[i]]);
      if (ra != rb) begin
        parent[ra] = rb;
        e = '{edge_src[order[i]], edge_dst[order[i]], edge_wt[order[i]], 1'b1, 1'b0};
        tree_q.push_back(e);
        kept++;
      end
    end
    if (kept == 0) begin
      tree_q.push_back('{4'd0, 4'd0, 16'd0, 1'b0, 1'b1});
    end else begin
      tree_q[tree_q.size()-1].last = 1'b1;
    end
    clear_load();
  endfunction

  function automatic void take_weight(logic [15:0] w);
    int n;
    n = side();
    if (entry_cnt >= n * n) clear_load();
    if (w != 0 && edge_cnt < Depth) begin
      edge_src[edge_cnt] = 4'(entry_cnt / n);
      edge_dst[edge_cnt] = 4'(entry_cnt % n);
      edge_wt[edge_cnt]  = w;
      edge_cnt++;
    end
    entry_cnt++;
    if (entry_cnt >= n * n) build_forest();
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors   = 0;
    side_reg = 5'(mstk_pkg::ResetVcount);
    clear_load();
  end

  always @(posedge clk_i) begin
    tree_edge_t exp_e;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == 2'(mstk_pkg::RegVcount * 4)) begin
        side_reg = pwdata_i[4:0];
        clear_load();
      end
      if (m_valid_i && m_ready_i) begin
        if (tree_q.size() == 0) begin
          report("unexpected item", m_data_i, 0);
        end else begin
          exp_e = tree_q.pop_front();
          if (m_data_i[3:0] != exp_e.from_v) report("from", m_data_i[3:0], exp_e.from_v);
          if (m_data_i[7:4] != exp_e.to_v) report("to", m_data_i[7:4], exp_e.to_v);
          if (m_data_i[23:8] != exp_e.wt) report("weight", m_data_i[23:8], exp_e.wt);
          if (m_data_i[24] != exp_e.has_edge)
            report("has_edge", m_data_i[24], exp_e.has_edge);
          if (m_last_i != exp_e.last) report("last", m_last_i, exp_e.last);
        end
      end
      if (s_valid_i && s_ready_i) take_weight(s_data_i);
    end
  end
endmodule

// ----- dv/tb_minimum_spanning_tree_kruskal_core.sv -----
// tb_minimum_spanning_tree_kruskal_core: stimulus and verdict for the kruskal core
// depends on mstk_pkg, minimum_spanning_tree_kruskal_core and mstk_scoreboard
`timescale 1ns / 1ps
module tb_minimum_spanning_tree_kruskal_core;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          sent;
  logic        calm = 1'b0;

  always #1 clk_i = ~clk_i;

  minimum_spanning_tree_kruskal_core dut (.*);

  mstk_scoreboard u_sb (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(pending)
  );

  task automatic set_side(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 2'(mstk_pkg::RegVcount * 4);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_weight(input logic [15:0] w);
    int gap;
    logic rdy;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  // density in percent, top is the largest weight drawn
  task automatic send_matrix(input int n, input int density, input int top);
    for (int i = 0; i < n * n; i++) begin
      if ($urandom_range(1, 100) <= density) send_weight(16'($urandom_range(1, top)));
      else send_weight(16'd0);
    end
  endtask

  always begin
    int gap;
    logic vld;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      m_axis_tready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    do begin
      @(negedge clk_i);
      vld = m_axis_tvalid;
      @(posedge clk_i);
    end while (!vld);
  end

  initial begin
    #2_000_000;
    $display("** minimum_spanning_tree_kruskal_core: FAILED **");
    $finish;
  end

  initial begin
    logic [15:0] pairs[5][4];
    int n;
    pairs = '{'{0, 0, 0, 0}, '{7, 0, 0, 16'hffff}, '{0, 16'hffff, 16'hffff, 0},
              '{0, 16'h5555, 16'haaaa, 0}, '{16'h8000, 1, 1, 0}};
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // smallest side: empty, self loops, both directions, extreme weights
    set_side(2);
    foreach (pairs[r, c]) send_weight(pairs[r][c]);
    drain();
    set_side(0);
    send_weight(16'h0001); send_weight(16'h0002); send_weight(16'h0002); send_weight(16'h0000);
    drain();
    set_side(1);
    calm = 1'b1;
    send_matrix(2, 100, 3);
    calm = 1'b0;
    drain();
    // largest side through an out of range value, sparse and full range
    set_side(31);
    send_matrix(16, 7, 16'hffff);
    drain();
    set_side(16);
    drain();
    while (sent < 350) begin
      n = $urandom_range(3, 5);
      set_side(n);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: send_matrix(n, 60, 4);
          1: send_matrix(n, 80, 16'hffff);
          2: send_matrix(n, 30, 20);
          default: send_matrix(n, 100, 16'hffff);
        endcase
      end
      calm = 1'b0;
      drain();
    end
    if (errors == 0) begin
      $display("** minimum_spanning_tree_kruskal_core: PASSED **");
    end else begin
      $display("** minimum_spanning_tree_kruskal_core: FAILED **");
    end
    $finish;
  end
endmodule
